// ----- rtl/sorg_pkg.sv -----
package sorg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int STEP_W = 4;

  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  localparam logic [30:0] NAT_FREQ_RESET = 31'd65536;
  localparam logic [30:0] DAMPING_RESET = 31'd45875;

  // Configuration register indexes
  typedef enum logic {
    CFG_NAT_FREQ = 1'b0,
    CFG_DAMPING  = 1'b1
  } cfg_idx_t;

  // Operand and destination codes of the datapath register file
  typedef enum logic [3:0] {
    SRC_ANG,
    SRC_VEL,
    SRC_ACC,
    SRC_JRK,
    SRC_SP,
    SRC_DT,
    SRC_OM,
    SRC_XI,
    SRC_T0,
    SRC_T1,
    SRC_T2
  } src_t;

  typedef enum logic [1:0] {
    ALU_NOP,
    ALU_ADD,
    ALU_SUB,
    ALU_NSUB
  } alu_op_t;

  typedef enum logic {
    SEQ_NEXT,
    SEQ_EMIT
  } seq_op_t;

  // One microcode control word
  typedef struct packed {
    logic    mul_en;
    src_t    mul_a;
    src_t    mul_b;
    logic    wb_en;
    src_t    wb_dst;
    alu_op_t alu_op;
    src_t    alu_a;
    src_t    alu_b;
    src_t    alu_dst;
    seq_op_t seq;
  } ctrl_t;

  localparam ctrl_t CTRL_IDLE = '{
    mul_en:  1'b0,
    mul_a:   SRC_ANG,
    mul_b:   SRC_ANG,
    wb_en:   1'b0,
    wb_dst:  SRC_T0,
    alu_op:  ALU_NOP,
    alu_a:   SRC_ANG,
    alu_b:   SRC_ANG,
    alu_dst: SRC_T0,
    seq:     SEQ_NEXT
  };

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/sorg_sequencer.sv -----
module sorg_sequencer
  import sorg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  out_free,
  output logic  busy,
  output logic  emit,
  output ctrl_t ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              busy_next;
  ctrl_t             cw;

  // Microprogram: one forward Euler update and the jerk evaluation.
  // Multiply at one step, write back the rescaled product at the next.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] s);
    ctrl_t c;
    c = CTRL_IDLE;
    case (s)
      4'd0: begin
        c.mul_en = 1'b1; c.mul_a = SRC_VEL; c.mul_b = SRC_DT;
      end
      4'd1: begin
        c.mul_en = 1'b1; c.mul_a = SRC_ACC; c.mul_b = SRC_DT;
        c.wb_en = 1'b1; c.wb_dst = SRC_T0;
      end
      4'd2: begin
        c.mul_en = 1'b1; c.mul_a = SRC_JRK; c.mul_b = SRC_DT;
        c.wb_en = 1'b1; c.wb_dst = SRC_T1;
        c.alu_op = ALU_ADD; c.alu_a = SRC_ANG; c.alu_b = SRC_T0; c.alu_dst = SRC_ANG;
      end
      4'd3: begin
        c.mul_en = 1'b1; c.mul_a = SRC_XI; c.mul_b = SRC_OM;
        c.wb_en = 1'b1; c.wb_dst = SRC_T2;
        c.alu_op = ALU_ADD; c.alu_a = SRC_VEL; c.alu_b = SRC_T1; c.alu_dst = SRC_VEL;
      end
      4'd4: begin
        c.mul_en = 1'b1; c.mul_a = SRC_OM; c.mul_b = SRC_OM;
        c.wb_en = 1'b1; c.wb_dst = SRC_T0;
        c.alu_op = ALU_ADD; c.alu_a = SRC_ACC; c.alu_b = SRC_T2; c.alu_dst = SRC_ACC;
      end
      4'd5: begin
        c.wb_en = 1'b1; c.wb_dst = SRC_T1;
        c.alu_op = ALU_ADD; c.alu_a = SRC_T0; c.alu_b = SRC_T0; c.alu_dst = SRC_T0;
      end
      4'd6: begin
        c.mul_en = 1'b1; c.mul_a = SRC_T0; c.mul_b = SRC_ACC;
        c.alu_op = ALU_SUB; c.alu_a = SRC_VEL; c.alu_b = SRC_SP; c.alu_dst = SRC_T2;
      end
      4'd7: begin
        c.mul_en = 1'b1; c.mul_a = SRC_T1; c.mul_b = SRC_T2;
        c.wb_en = 1'b1; c.wb_dst = SRC_T0;
      end
      4'd8: begin
        c.wb_en = 1'b1; c.wb_dst = SRC_T1;
      end
      4'd9: begin
        c.alu_op = ALU_NSUB; c.alu_a = SRC_T0; c.alu_b = SRC_T1; c.alu_dst = SRC_JRK;
      end
      4'd10: begin
        c.seq = SEQ_EMIT;
      end
      default: begin
        c.seq = SEQ_EMIT;
      end
    endcase
    return c;
  endfunction

  assign cw = ucode(step);

  // Emit is a conditional jump back to idle; hold the step while the
  // output register is still occupied.
  assign emit = busy && (cw.seq == SEQ_EMIT) && out_free;

  always_comb begin
    busy_next = busy;
    step_next = step;
    if (start) begin
      busy_next = 1'b1;
      step_next = '0;
    end else if (emit) begin
      busy_next = 1'b0;
    end else if (busy && (cw.seq == SEQ_NEXT)) begin
      step_next = step + 1'b1;
    end
  end

  always_comb begin
    ctrl = cw;
    if (!busy) begin
      ctrl = CTRL_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

endmodule

// ----- rtl/sorg_datapath.sv -----
module sorg_datapath
  import sorg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ctrl_t              ctrl,
  input  logic               load,
  input  logic signed [31:0] velocity_setpoint,
  input  logic [30:0]        step_time,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [30:0]        cfg_data,
  output logic signed [31:0] ref_angle,
  output logic signed [31:0] ref_velocity,
  output logic signed [31:0] ref_accel,
  output logic signed [31:0] ref_jerk
);

  logic signed [31:0] angle_acc;
  logic signed [31:0] velocity_acc;
  logic signed [31:0] accel_acc;
  logic signed [31:0] jerk_acc;
  logic signed [31:0] setpoint;
  logic [30:0]        dt;
  logic [30:0]        natural_frequency;
  logic [30:0]        damping_ratio;
  logic signed [31:0] t0;
  logic signed [31:0] t1;
  logic signed [31:0] t2;
  logic signed [63:0] prod;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] alu_a;
  logic signed [31:0] alu_b;
  logic signed [63:0] alu_a_x;
  logic signed [63:0] alu_b_x;
  logic signed [63:0] alu_sum;
  logic signed [31:0] alu_res;
  logic signed [31:0] wb_res;

  function automatic logic signed [31:0] rd(
    input src_t               s,
    input logic signed [31:0] ang,
    input logic signed [31:0] vel,
    input logic signed [31:0] acc,
    input logic signed [31:0] jrk,
    input logic signed [31:0] sp,
    input logic [30:0]        d,
    input logic [30:0]        om,
    input logic [30:0]        xi,
    input logic signed [31:0] r0,
    input logic signed [31:0] r1,
    input logic signed [31:0] r2
  );
    logic signed [31:0] v;
    case (s)
      SRC_ANG: v = ang;
      SRC_VEL: v = vel;
      SRC_ACC: v = acc;
      SRC_JRK: v = jrk;
      SRC_SP:  v = sp;
      SRC_DT:  v = {1'b0, d};
      SRC_OM:  v = {1'b0, om};
      SRC_XI:  v = {1'b0, xi};
      SRC_T0:  v = r0;
      SRC_T1:  v = r1;
      SRC_T2:  v = r2;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign mul_a = rd(ctrl.mul_a, angle_acc, velocity_acc, accel_acc, jerk_acc, setpoint, dt,
                    natural_frequency, damping_ratio, t0, t1, t2);
  assign mul_b = rd(ctrl.mul_b, angle_acc, velocity_acc, accel_acc, jerk_acc, setpoint, dt,
                    natural_frequency, damping_ratio, t0, t1, t2);
  assign alu_a = rd(ctrl.alu_a, angle_acc, velocity_acc, accel_acc, jerk_acc, setpoint, dt,
                    natural_frequency, damping_ratio, t0, t1, t2);
  assign alu_b = rd(ctrl.alu_b, angle_acc, velocity_acc, accel_acc, jerk_acc, setpoint, dt,
                    natural_frequency, damping_ratio, t0, t1, t2);

  assign alu_a_x = {{32{alu_a[31]}}, alu_a};
  assign alu_b_x = {{32{alu_b[31]}}, alu_b};

  always_comb begin
    case (ctrl.alu_op)
      ALU_ADD:  alu_sum = alu_a_x + alu_b_x;
      ALU_SUB:  alu_sum = alu_a_x - alu_b_x;
      ALU_NSUB: alu_sum = -alu_a_x - alu_b_x;
      default:  alu_sum = alu_a_x;
    endcase
  end

  assign alu_res = sat32(alu_sum);
  // Floor rescale of the registered product
  assign wb_res = sat32(prod >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      setpoint <= velocity_setpoint;
      dt       <= step_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      natural_frequency <= NAT_FREQ_RESET;
      damping_ratio     <= DAMPING_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NAT_FREQ: natural_frequency <= cfg_data;
        CFG_DAMPING:  damping_ratio     <= cfg_data;
        default:      ;
      endcase
    end
  end

  // State and scratch registers; the program never writes the same
  // destination from both ports in one step.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_acc    <= '0;
      velocity_acc <= '0;
      accel_acc    <= '0;
      jerk_acc     <= '0;
    end else begin
      if (ctrl.alu_op != ALU_NOP) begin
        case (ctrl.alu_dst)
          SRC_ANG: angle_acc    <= alu_res;
          SRC_VEL: velocity_acc <= alu_res;
          SRC_ACC: accel_acc    <= alu_res;
          SRC_JRK: jerk_acc     <= alu_res;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.alu_op != ALU_NOP) begin
      case (ctrl.alu_dst)
        SRC_T0:  t0 <= alu_res;
        SRC_T1:  t1 <= alu_res;
        SRC_T2:  t2 <= alu_res;
        default: ;
      endcase
    end
    if (ctrl.wb_en) begin
      case (ctrl.wb_dst)
        SRC_T0:  t0 <= wb_res;
        SRC_T1:  t1 <= wb_res;
        SRC_T2:  t2 <= wb_res;
        default: ;
      endcase
    end
  end

  assign ref_angle    = angle_acc;
  assign ref_velocity = velocity_acc;
  assign ref_accel    = accel_acc;
  assign ref_jerk     = jerk_acc;

endmodule

// ----- rtl/second_order_reference_generator_unit.sv -----
// Channel   Direction  Transaction                 Payload
// s_*       in         one setpoint and time step  tdata: velocity_setpoint, step_time
// m_*       out        updated reference state     tdata: angle, velocity, accel, jerk
// cfg_*     in         register write              cfg_addr: 0 omega, 1 xi
//
// An item passes through the 11-step microprogram, which shares one 32x32
// multiplier and one saturating adder, on its way to the result register.
// A new item is accepted in the cycle the previous result is loaded, so the
// block takes no new item while it is still working on the last one.
// Reset (rst, synchronous) zeroes the state and restores omega = 1.0, xi = 0.7.
// A stalled output holds the sequencer at its final step until m_tready.
module second_order_reference_generator_unit
  import sorg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // [31:0] velocity_setpoint, [62:32] step_time, [63] zero
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // [31:0] ref_angle, [63:32] ref_velocity,
                                  // [95:64] ref_accel, [127:96] ref_jerk
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [30:0]  cfg_data
);

  logic               busy;
  logic               emit;
  logic               start;
  logic               out_free;
  ctrl_t              ctrl;
  logic signed [31:0] ref_angle;
  logic signed [31:0] ref_velocity;
  logic signed [31:0] ref_accel;
  logic signed [31:0] ref_jerk;

  // Output register is free when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;
  // Take a new item while idle or in the cycle the last result leaves
  assign s_tready = !busy || emit;
  assign start    = s_tvalid && s_tready;

  sorg_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .busy     (busy),
    .emit     (emit),
    .ctrl     (ctrl)
  );

  sorg_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .load              (start),
    .velocity_setpoint (s_tdata[31:0]),
    .step_time         (s_tdata[62:32]),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_data          (cfg_data),
    .ref_angle         (ref_angle),
    .ref_velocity      (ref_velocity),
    .ref_accel         (ref_accel),
    .ref_jerk          (ref_jerk)
  );

  // Result register: load on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {ref_jerk, ref_accel, ref_velocity, ref_angle};
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("sequencer not busy after accepting an item");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!m_tvalid || m_tready))
    else $error("result emitted over an unread result");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_tvalid)
    else $error("emitted result not presented");

  a_no_emit_when_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !emit)
    else $error("emit while sequencer idle");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb
  import sorg_pkg::*;
;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 123;
  localparam int HOLD_CYCLES = 400;
  localparam logic [30:0] REG_MAX = 31'h7FFFFFFF;
  localparam logic [30:0] DT_MAX = 31'h7FFFFFFF;

  // Reference state as it sits on m_tdata, ref_angle in the lowest word
  typedef struct packed {
    logic signed [31:0] jerk;
    logic signed [31:0] accel;
    logic signed [31:0] vel;
    logic signed [31:0] angle;
  } ref_state_t;

  // Tracks omega, xi and the four state words; every accepted setpoint
  // advances the state one Euler step and queues the resulting state.
  class reference_state_tracker;
    logic [30:0] nat_freq;
    logic [30:0] damping;
    ref_state_t cur;
    ref_state_t expected_states[$];
    int errors;

    function new();
      nat_freq = NAT_FREQ_RESET;
      damping = DAMPING_RESET;
      cur = '0;
      errors = 0;
    endfunction

    static function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Exact product, floor rescale, then clamp
    static function longint scaled_product(longint a, longint b);
      longint p;
      p = a * b;
      return clamp(p >>> FRAC_BITS);
    endfunction

    function void set_register(cfg_idx_t idx, logic [30:0] val);
      case (idx)
        CFG_NAT_FREQ: nat_freq = val;
        CFG_DAMPING: damping = val;
        default: ;
      endcase
    endfunction

    function void note_setpoint(logic signed [31:0] sp, logic [30:0] dt);
      longint ang, vel, acc, jrk, d, om, xi;
      longint xo, c1, ww, err, t1, t2;
      ang = cur.angle;
      vel = cur.vel;
      acc = cur.accel;
      jrk = cur.jerk;
      d = dt;
      om = nat_freq;
      xi = damping;
      // Integrate each term with the old value of the next one
      ang = clamp(ang + scaled_product(vel, d));
      vel = clamp(vel + scaled_product(acc, d));
      acc = clamp(acc + scaled_product(jrk, d));
      // Jerk from the new acceleration and the new velocity error
      xo = scaled_product(xi, om);
      c1 = clamp(2 * xo);
      ww = scaled_product(om, om);
      err = clamp(vel - sp);
      t1 = scaled_product(c1, acc);
      t2 = scaled_product(ww, err);
      jrk = clamp(-t1 - t2);
      cur.angle = ang[31:0];
      cur.vel = vel[31:0];
      cur.accel = acc[31:0];
      cur.jerk = jrk[31:0];
      expected_states.push_back(cur);
    endfunction

    function void compare_field(string label, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s expected %0d actual %0d", $time, label, want, got);
      end
    endfunction

    function void check_state(logic [127:0] data);
      ref_state_t got;
      ref_state_t want;
      got = data;
      if (expected_states.size() == 0) begin
        errors++;
        $display("%0t ns: state expected none actual %h", $time, data);
        return;
      end
      want = expected_states.pop_front();
      compare_field("ref_angle", want.angle, got.angle);
      compare_field("ref_velocity", want.vel, got.vel);
      compare_field("ref_accel", want.accel, got.accel);
      compare_field("ref_jerk", want.jerk, got.jerk);
    endfunction

    function int pending();
      return expected_states.size();
    endfunction
  endclass

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;   // [31:0] velocity_setpoint, [62:32] step_time, [63] zero
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // [31:0] ref_angle, [63:32] ref_velocity,
                                // [95:64] ref_accel, [127:96] ref_jerk
  logic         cfg_we = 1'b0;
  logic         cfg_addr = 1'b0;
  logic [30:0]  cfg_data = '0;

  reference_state_tracker tracker = new();

  // Idling controls for the two sides; set per phase
  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;
  bit hold_req = 1'b0;
  int cycles = 0;

  second_order_reference_generator_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one setpoint transaction; lower tvalid only when a gap is drawn so
  // that back-to-back items keep tvalid high without a second assignment.
  task automatic send_setpoint(logic signed [31:0] sp, logic [30:0] dt);
    int gap;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, dt, sp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_setpoint(sp, dt);
  endtask

  // Mostly well-behaved steps: small dt and setpoints of every magnitude.
  // Mix in raw noise over all bits and some zero-dt steps.
  task automatic send_random_setpoint();
    logic signed [31:0] sp;
    logic [30:0] dt;
    int pick;
    pick = $urandom_range(0, 99);
    sp = $urandom;
    if (pick < 8) begin
      dt = 31'($urandom);
    end else if (pick < 14) begin
      sp = sp >>> $urandom_range(3, 31);
      dt = '0;
    end else begin
      sp = sp >>> $urandom_range(3, 31);
      dt = 31'($urandom_range(1, 31'h1000));
    end
    send_setpoint(sp, dt);
  endtask

  // Drain every outstanding state, then write omega and xi while idle
  task automatic write_registers(logic [30:0] om, logic [30:0] xi);
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_NAT_FREQ;
    cfg_data <= om;
    @(posedge clk);
    tracker.set_register(CFG_NAT_FREQ, om);
    cfg_addr <= CFG_DAMPING;
    cfg_data <= xi;
    @(posedge clk);
    tracker.set_register(CFG_DAMPING, xi);
    cfg_we <= 1'b0;
  endtask

  // Result side: draw a stall per transaction, or the long hold-off when asked
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = snk_idle ? $urandom_range(0, 19) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      tracker.check_state(m_tdata);
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [30:0] om;
    logic [30:0] xi;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset omega and xi, zero dt, field extremes, saturation
    send_setpoint(32'sd0, 31'd0);
    send_setpoint(32'sh7FFFFFFF, 31'd0);
    send_setpoint(32'sh80000000, 31'd0);
    send_setpoint(32'sd65536, 31'h10000);
    send_setpoint(-32'sd65536, 31'h1000);
    send_setpoint(32'sd1, 31'd1);
    send_setpoint(-32'sd1, DT_MAX);
    send_setpoint(32'sh7FFFFFFF, DT_MAX);
    send_setpoint(32'sh80000000, DT_MAX);
    send_setpoint(32'sd0, DT_MAX);
    send_setpoint(32'sh80000000, 31'h800);
    // Largest omega and xi: gain terms clamp
    write_registers(REG_MAX, REG_MAX);
    send_setpoint(32'sd0, 31'h100);
    send_setpoint(32'sh7FFFFFFF, 31'h100);
    send_setpoint(32'sh80000000, 31'd0);
    send_setpoint(32'sh55555555, 31'h2AAAAAAA);
    // Zero omega and xi: jerk collapses to zero
    write_registers('0, '0);
    send_setpoint(32'shAAAAAAAA, 31'h55555555);
    send_setpoint(32'sd12345, 31'h1000);
    send_setpoint(-32'sd12345, 31'd0);
    // Back to a stable setting so the state can settle
    write_registers(31'h10000, 31'hB333);
    send_setpoint(32'sd0, 31'h800);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        2: begin
          om = REG_MAX;
          xi = REG_MAX;
        end
        4: begin
          om = '0;
          xi = '0;
        end
        6: begin
          om = REG_MAX;
          xi = '0;
        end
        8: begin
          om = '0;
          xi = REG_MAX;
        end
        default: begin
          om = 31'($urandom_range(31'h4000, 31'h80000));
          xi = 31'($urandom_range(31'h3000, 31'h1C000));
        end
      endcase
      write_registers(om, xi);
      // Vary idling per phase; some phases run with no gaps at all
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      // Stall the result side long enough to back up the input
      if (ph == 5) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_setpoint();
      end
    end

    // Let the last states come back, then allow the pipeline to settle
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
